// ----- rtl/hbid_pkg.sv -----
// ----------------------------------------------------------------------------
// hbid_pkg
// Shared types and constants of the heart beat interval detector.
// ----------------------------------------------------------------------------
package hbid_pkg;

  localparam int SampleBits = 18;
  localparam int HistDepth  = 8;
  localparam int IdxW       = $clog2(HistDepth);
  localparam int FillW      = $clog2(HistDepth + 1);

  // baseline in Q.8, residual is one bit wider and signed
  localparam int BaseW   = SampleBits + 8;
  localparam int ResW    = BaseW + 1;
  localparam int SqW     = 2 * BaseW;
  localparam int MsShift = (2 * SampleBits > 28) ? (2 * SampleBits - 28) : 0;
  localparam int MsOne   = (MsShift < 16) ? (1 << (16 - MsShift)) : 1;
  localparam int MsW     = 44;
  localparam int ThShift = 32 - MsShift;
  localparam int ThW     = 32 + MsW - ThShift + 1;

  localparam int DivW    = 20;
  localparam int DivNum  = 600000;
  localparam int RateMax = 4095;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam int InDataW  = 56;
  localparam int OutDataW = 56;

  typedef enum logic [1:0] {
    CfgBaselineGain   = 2'd0,
    CfgPowerGain      = 2'd1,
    CfgThresholdFactor = 2'd2,
    CfgRefractoryMs   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] baseline_gain;
    logic [15:0] power_gain;
    logic [15:0] threshold_factor;
    logic [11:0] refractory_ms;
  } cfg_t;

  typedef struct packed {
    logic                  restart;
    logic [SampleBits-1:0] sample;
    logic [31:0]           time_ms;
  } item_t;

  typedef struct packed {
    logic        beat;
    logic [15:0] interval_ms;
    logic [11:0] rate_tenths;
    logic [3:0]  history_count;
    logic [16:0] median_half_ms;
  } result_t;

  typedef enum logic [3:0] {
    StIdle,
    StMulBase,
    StUpdBase,
    StMag,
    StSquare,
    StMulMs,
    StUpdMs,
    StMulTh,
    StSumTh,
    StDecide,
    StDivide,
    StMedian,
    StOut
  } back_state_e;

endpackage

// ----- rtl/hbid_front.sv -----
// ----------------------------------------------------------------------------
// hbid_front
// Input side: takes stream transfers, sorts restart from sample items and
// holds them in a short queue for the processing engine.
// ----------------------------------------------------------------------------
module hbid_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [hbid_pkg::InDataW-1:0] s_axis_tdata,
  input  logic                      s_axis_tuser,
  output logic                      q_valid_o,
  output hbid_pkg::item_t           q_item_o,
  input  logic                      q_pop_i
);
  import hbid_pkg::*;

  item_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;
  item_t            item_in;

  always_comb begin
    item_in.restart = s_axis_tuser;
    item_in.sample  = s_axis_tdata[SampleBits-1:0];
    item_in.time_ms = s_axis_tdata[SampleBits +: 32];
  end

  assign s_axis_tready = (cnt_q != QCntW'(QueueDepth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != '0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_item_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- rtl/hbid_back.sv -----
// ----------------------------------------------------------------------------
// hbid_back
// Processing engine: baseline and power averages, threshold test, interval
// history, rate division and median, one step per cycle, waiting for a free result register; result register.
// ----------------------------------------------------------------------------
module hbid_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hbid_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  hbid_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            res_valid_o,
  output hbid_pkg::result_t res_o,
  input  logic            res_ready_i
);
  import hbid_pkg::*;

  localparam int PbW  = ResW + 17;
  localparam int SbW  = PbW - 16;
  localparam int DmW  = MsW + 1;
  localparam int PmW  = DmW + 17;
  localparam int SmW  = PmW - 16;
  localparam int DCntW = $clog2(DivW + 1);
  localparam logic [BaseW-1:0] BaseMax = {{SampleBits{1'b1}}, 8'd0};

  back_state_e state_q, state_d;

  item_t                cur_q;
  logic [BaseW-1:0]     base_q;
  logic [MsW-1:0]       ms_q;
  logic                 prev_pos_q;
  logic [SqW-1:0]       prev_sq_q;
  logic [15:0]          hist_q [HistDepth];
  logic [FillW-1:0]     fill_q;
  logic [31:0]          last_q;
  logic                 seen_q;

  logic signed [PbW-1:0] pb_q;
  logic [31:0]           f2_q;
  logic [BaseW-1:0]      mag_q;
  logic                  acpos_q;
  logic [SqW-1:0]        sq_q;
  logic signed [PmW-1:0] pm_q;
  logic [31+MsW-ThShift:0] ph_q;
  logic [31+ThShift:0]   pl_q;
  logic [ThW-1:0]        t_q;

  logic [DivW-1:0]  num_q, quo_q;
  logic [16:0]      rem_q;
  logic [DCntW-1:0] dcnt_q;
  logic [FillW-1:0] k_q;
  logic [15:0]      a1_q, a2_q;

  result_t res_q;
  logic    res_valid_q;

  // combinational datapath
  logic signed [ResW-1:0] db, ac;
  logic signed [PbW-1:0]  pb_d, pb_r;
  logic signed [SbW-1:0]  stepb;
  logic signed [SbW:0]    sumb;
  logic [BaseW-1:0]       base_d;
  logic signed [DmW-1:0]  dm;
  logic signed [PmW-1:0]  pm_d, pm_r;
  logic signed [SmW-1:0]  stepm;
  logic signed [SmW:0]    summ;
  logic [MsW-1:0]         ms_d;
  logic                   above, below_prev, crossing, take;
  logic [31:0]            dt;
  logic [15:0]            interval;
  logic [17:0]            rs;
  logic                   qbit;
  logic [DivW-1:0]        quo_d;
  logic [15:0]            cand;
  logic [FillW-1:0]       less_cnt, le_cnt, m1, m2;
  logic [15:0]            a1_d, a2_d;
  logic                   out_free;

  always_comb begin
    db    = $signed({1'b0, cur_q.sample, 8'd0}) - $signed({1'b0, base_q});
    pb_d  = db * $signed({1'b0, cfg_i.baseline_gain});
    pb_r  = pb_q + $signed(PbW'(32768));
    stepb = pb_r[PbW-1:16];
    sumb  = $signed({{(SbW+1-BaseW){1'b0}}, base_q}) + $signed({stepb[SbW-1], stepb});
    if (sumb[SbW])                           base_d = '0;
    else if (sumb > $signed({1'b0, {(SbW-BaseW){1'b0}}, BaseMax})) base_d = BaseMax;
    else                                     base_d = sumb[BaseW-1:0];

    ac = $signed({1'b0, cur_q.sample, 8'd0}) - $signed({1'b0, base_q});

    dm    = $signed({1'b0, sq_q[SqW-1:MsShift]}) - $signed({1'b0, ms_q});
    pm_d  = dm * $signed({1'b0, cfg_i.power_gain});
    pm_r  = pm_q + $signed(PmW'(32768));
    stepm = pm_r[PmW-1:16];
    summ  = $signed({{(SmW+1-MsW){1'b0}}, ms_q}) + $signed({stepm[SmW-1], stepm});
    if (summ[SmW])                                   ms_d = '0;
    else if (summ[SmW-1:MsW] != '0)                  ms_d = '1;
    else                                             ms_d = summ[MsW-1:0];

    above      = acpos_q && ({1'b0, sq_q} > t_q);
    below_prev = !prev_pos_q || ({1'b0, prev_sq_q} <= t_q);
    crossing   = above && below_prev;
    dt         = cur_q.time_ms - last_q;
    take       = crossing && (!seen_q || (dt > {20'd0, cfg_i.refractory_ms}));
    interval   = (dt > 32'd65535) ? 16'hFFFF : dt[15:0];

    rs    = {rem_q, num_q[DivW-1]};
    qbit  = (rs >= {2'b00, res_q.interval_ms});
    quo_d = {quo_q[DivW-2:0], qbit};

    // rank of the candidate entry among the held intervals
    cand     = hist_q[k_q[IdxW-1:0]];
    less_cnt = '0;
    le_cnt   = '0;
    for (int j = 0; j < HistDepth; j++) begin
      if (FillW'(j) < fill_q) begin
        if (hist_q[j] < cand)  less_cnt = less_cnt + 1'b1;
        if (hist_q[j] <= cand) le_cnt   = le_cnt + 1'b1;
      end
    end
    m2   = fill_q >> 1;
    m1   = fill_q[0] ? m2 : m2 - 1'b1;
    a1_d = ((less_cnt <= m1) && (m1 < le_cnt)) ? cand : a1_q;
    a2_d = ((less_cnt <= m2) && (m2 < le_cnt)) ? cand : a2_q;

    out_free = !res_valid_q || res_ready_i;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = q_item_i.restart ? StOut : StMulBase;
        end
      end
      StMulBase: state_d = StUpdBase;
      StUpdBase: state_d = StMag;
      StMag:     state_d = StSquare;
      StSquare:  state_d = StMulMs;
      StMulMs:   state_d = StUpdMs;
      StUpdMs:   state_d = StMulTh;
      StMulTh:   state_d = StSumTh;
      StSumTh:   state_d = StDecide;
      StDecide: begin
        if (take && seen_q && (interval != '0)) state_d = StDivide;
        else                                    state_d = StMedian;
      end
      StDivide: begin
        if (dcnt_q == DCntW'(DivW - 1)) state_d = StMedian;
      end
      StMedian: begin
        if ((fill_q == '0) || (k_q == fill_q - 1'b1)) state_d = StOut;
      end
      StOut: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        cur_q <= q_item_i;
        res_q <= '0;
      end
      StMulBase: begin
        pb_q <= pb_d;
        f2_q <= cfg_i.threshold_factor * cfg_i.threshold_factor;
      end
      StMag: begin
        mag_q   <= ac[ResW-1] ? BaseW'(-ac) : ac[BaseW-1:0];
        acpos_q <= !ac[ResW-1] && (ac != '0);
      end
      StSquare: sq_q <= mag_q * mag_q;
      StMulMs:  pm_q <= pm_d;
      StMulTh: begin
        ph_q <= f2_q * ms_q[MsW-1:ThShift];
        pl_q <= f2_q * ms_q[ThShift-1:0];
      end
      StSumTh: t_q <= ThW'(ph_q) + ThW'(pl_q >> ThShift);
      StDecide: begin
        k_q  <= '0;
        a1_q <= '0;
        a2_q <= '0;
        if (take && seen_q) begin
          res_q.beat        <= 1'b1;
          res_q.interval_ms <= interval;
          num_q  <= DivW'(DivNum) + DivW'(interval >> 1);
          rem_q  <= '0;
          quo_q  <= '0;
          dcnt_q <= '0;
        end
      end
      StDivide: begin
        rem_q  <= qbit ? 17'(rs - {2'b00, res_q.interval_ms}) : rs[16:0];
        quo_q  <= quo_d;
        num_q  <= num_q << 1;
        dcnt_q <= dcnt_q + 1'b1;
        if (dcnt_q == DCntW'(DivW - 1)) begin
          res_q.rate_tenths <= (quo_d > DivW'(RateMax)) ? 12'(RateMax) : quo_d[11:0];
        end
      end
      StMedian: begin
        k_q  <= k_q + 1'b1;
        a1_q <= a1_d;
        a2_q <= a2_d;
        res_q.history_count <= (fill_q > FillW'(15)) ? 4'd15 : 4'(fill_q);
        res_q.median_half_ms <= (fill_q == '0) ? '0 : 17'(a1_d) + 17'(a2_d);
      end
      default: ;
    endcase
  end

  // detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      ms_q       <= MsW'(MsOne);
      prev_pos_q <= 1'b0;
      prev_sq_q  <= '0;
      fill_q     <= '0;
      last_q     <= '0;
      seen_q     <= 1'b0;
    end else begin
      if (state_q == StIdle && q_valid_i && q_item_i.restart) begin
        base_q     <= '0;
        ms_q       <= MsW'(MsOne);
        prev_pos_q <= 1'b0;
        prev_sq_q  <= '0;
        fill_q     <= '0;
        last_q     <= '0;
        seen_q     <= 1'b0;
      end
      if (state_q == StUpdBase) base_q <= base_d;
      if (state_q == StUpdMs)   ms_q   <= ms_d;
      if (state_q == StDecide) begin
        prev_pos_q <= acpos_q;
        prev_sq_q  <= sq_q;
        if (take) begin
          last_q <= cur_q.time_ms;
          seen_q <= 1'b1;
          if (seen_q && fill_q < FillW'(HistDepth)) fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  // interval history, oldest entry at index zero
  always_ff @(posedge clk_i) begin
    if (state_q == StDecide && take && seen_q) begin
      if (fill_q < FillW'(HistDepth)) begin
        hist_q[fill_q[IdxW-1:0]] <= interval;
      end else begin
        for (int i = 0; i < HistDepth - 1; i++) hist_q[i] <= hist_q[i+1];
        hist_q[HistDepth-1] <= interval;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      if (state_q == StOut && out_free) res_valid_q <= 1'b1;
      else if (res_ready_i)             res_valid_q <= 1'b0;
    end
  end

  result_t res_out_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StOut && out_free) res_out_q <= res_q;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_out_q;

endmodule

// ----- rtl/heart_beat_interval_detector_top.sv -----
// ----------------------------------------------------------------------------
// heart_beat_interval_detector_top
// Adaptive threshold beat detector with interval history, rate and median.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        tdata: sample, time_ms; tuser: op
//  m_axis    out        tvalid / tready        tdata: interval..median; tuser: beat
//  cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a sample result passes the baseline, power, threshold and decide steps, then
// one median step per held interval (at least one), with the bit-serial rate
// division before it when a beat has a nonzero interval; a restart goes straight
// to the output step, and a two-entry queue takes input meanwhile
// the result register lets the engine finish the next item while m_axis stalls
// reset clears the detector state and loads the register defaults
module heart_beat_interval_detector_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [17:0] sample, [49:18] time_ms, zero padding above
  input  logic [55:0] s_axis_tdata,
  // [0] op
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] interval_ms, [27:16] rate_tenths, [31:28] history_count,
  // [48:32] median_half_ms, zero padding above
  output logic [55:0] m_axis_tdata,
  // [0] beat
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import hbid_pkg::*;

  cfg_t    cfg_q;
  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baseline_gain    <= 16'd655;
      cfg_q.power_gain       <= 16'd1966;
      cfg_q.threshold_factor <= 16'd29491;
      cfg_q.refractory_ms    <= 12'd280;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgBaselineGain:    cfg_q.baseline_gain    <= cfg_data_i;
        CfgPowerGain:       cfg_q.power_gain       <= cfg_data_i;
        CfgThresholdFactor: cfg_q.threshold_factor <= cfg_data_i;
        CfgRefractoryMs:    cfg_q.refractory_ms    <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  hbid_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  hbid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tuser = res.beat;
  assign m_axis_tdata = {7'd0, res.median_half_ms, res.history_count,
                         res.rate_tenths, res.interval_ms};

endmodule
